// ----- rtl/pqlda_pkg.sv -----
// Shared types and constants for the product-quantization distance accumulator.
// Depends on nothing; every other file of the block but pqlda_ram refers to it by scoped names.
`timescale 1ns / 1ps

package pqlda_pkg;

  // Sizes fixed by the field widths of the interface.
  localparam int unsigned ADDR_W      = 14;
  localparam int unsigned TABLE_DEPTH = 1 << ADDR_W;
  localparam int unsigned ENTRY_W     = 32;
  localparam int unsigned SUM_W       = 40;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned NIBBLE_W    = 4;
  localparam int unsigned COUNT_W     = 7;
  localparam int unsigned STRIDE_W    = 9;
  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 9;

  // Depth of the command queue between front and back.
  localparam int unsigned QUEUE_DEPTH = 4;

  // Default structural limits.
  localparam int unsigned MAX_SUBQUANTIZERS_DEF = 64;
  localparam int unsigned MAX_CODEBOOK_DEF      = 256;

  // Operation codes of an input request.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_CODE  = 1'b1;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SQ   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CODEBOOK = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED   = 2'd2;

  // Reset values of the configuration registers.
  localparam logic [COUNT_W-1:0]  NUM_SQ_RST   = 7'd8;
  localparam logic [STRIDE_W-1:0] CODEBOOK_RST = 9'd16;
  localparam logic                PACKED_RST   = 1'b1;

  typedef struct packed {
    logic [COUNT_W-1:0]  num_sq;
    logic [STRIDE_W-1:0] codebook;
    logic                packed_mode;
  } cfg_t;

  // One classified command as it travels from front to back.
  typedef struct packed {
    logic               is_write;
    logic [ADDR_W-1:0]  addr0;
    logic [ADDR_W-1:0]  addr1;
    logic [ENTRY_W-1:0] value;
    logic               use1;
    logic               last;
  } cmd_t;

endpackage

// ----- rtl/pq_lookup_distance_accumulator_core.sv -----
// Top level of the product-quantization lookup distance accumulator.
// Depends on pqlda_pkg, pqlda_front, pqlda_queue, pqlda_back and pqlda_ram.
`timescale 1ns / 1ps

// Channel   Direction  Handshake              Payload
// ------    ---------  ---------------------  -----------------------------------------
// input     in         in_valid_i/in_stall_o  operation_i, entry_address_i,
//                                             entry_value_i, code_byte_i
// output    out        out_valid_o/out_stall_i distance_o
// config    in         cfg_we_i               cfg_index_i, cfg_data_i
//
// One request is taken every cycle while the command queue has room. The back end reads
// both table entries of a packed byte in parallel from two table copies. The request that
// completes a vector passes the queue, the table read registers and the result register.
// Reset clears the position, the accumulator and the queue but not the table, which has no
// clearing pass and must be written before use. A stalled result freezes the back end; the
// queue then fills and raises in_stall_o.
//
// The front end tracks the sub-quantizer position and turns each code byte into one or
// two table addresses (position times stride plus code, wrapped to the table size) and an
// end-of-vector flag. Entry writes travel through the same queue, so writes and lookups
// reach the table strictly in request order. The back end issues the table access, then
// adds the sign-extended entries into the 40-bit running sum, which wraps on overflow.
// Configuration registers are read directly by the front end; they are to be written only
// while the block is idle, which the user must see to, as the block does not enforce it.

module pq_lookup_distance_accumulator_core #(
  parameter int unsigned MAX_SUBQUANTIZERS = pqlda_pkg::MAX_SUBQUANTIZERS_DEF,
  parameter int unsigned MAX_CODEBOOK      = pqlda_pkg::MAX_CODEBOOK_DEF
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  cfg_we_i,
  input  logic [pqlda_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pqlda_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic                                  in_valid_i,
  output logic                                  in_stall_o,
  input  logic                                  operation_i,
  input  logic [pqlda_pkg::ADDR_W-1:0]          entry_address_i,
  input  logic signed [pqlda_pkg::ENTRY_W-1:0]  entry_value_i,
  input  logic [pqlda_pkg::BYTE_W-1:0]          code_byte_i,
  output logic                                  out_valid_o,
  input  logic                                  out_stall_i,
  output logic signed [pqlda_pkg::SUM_W-1:0]    distance_o
);

  pqlda_pkg::cfg_t cfg_q, cfg_d;
  pqlda_pkg::cmd_t push_cmd, head_cmd;
  logic            push, pop, q_full, q_valid;

  // Configuration registers; writes to an index beyond the list are ignored.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_index_i)
        pqlda_pkg::CFG_NUM_SQ:   cfg_d.num_sq      = cfg_data_i[pqlda_pkg::COUNT_W-1:0];
        pqlda_pkg::CFG_CODEBOOK: cfg_d.codebook    = cfg_data_i[pqlda_pkg::STRIDE_W-1:0];
        pqlda_pkg::CFG_PACKED:   cfg_d.packed_mode = cfg_data_i[0];
        default: cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.num_sq      <= pqlda_pkg::NUM_SQ_RST;
      cfg_q.codebook    <= pqlda_pkg::CODEBOOK_RST;
      cfg_q.packed_mode <= pqlda_pkg::PACKED_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  pqlda_front #(
    .MAX_SUBQUANTIZERS (MAX_SUBQUANTIZERS),
    .MAX_CODEBOOK      (MAX_CODEBOOK)
  ) u_front (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg_q),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .entry_address_i (entry_address_i),
    .entry_value_i   (entry_value_i),
    .code_byte_i     (code_byte_i),
    .q_full_i        (q_full),
    .push_o          (push),
    .cmd_o           (push_cmd)
  );

  pqlda_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .cmd_i   (push_cmd),
    .full_o  (q_full),
    .pop_i   (pop),
    .valid_o (q_valid),
    .cmd_o   (head_cmd)
  );

  pqlda_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .cmd_i       (head_cmd),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .distance_o  (distance_o)
  );

endmodule

// ----- rtl/pqlda_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing.
`timescale 1ns / 1ps

module pqlda_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/pqlda_front.sv -----
// Front end: accepts requests, tracks the sub-quantizer position and forms table addresses.
// Depends on pqlda_pkg.
`timescale 1ns / 1ps

module pqlda_front #(
  parameter int unsigned MAX_SUBQUANTIZERS = pqlda_pkg::MAX_SUBQUANTIZERS_DEF,
  parameter int unsigned MAX_CODEBOOK      = pqlda_pkg::MAX_CODEBOOK_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pqlda_pkg::cfg_t                     cfg_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic                                operation_i,
  input  logic [pqlda_pkg::ADDR_W-1:0]        entry_address_i,
  input  logic signed [pqlda_pkg::ENTRY_W-1:0] entry_value_i,
  input  logic [pqlda_pkg::BYTE_W-1:0]        code_byte_i,
  input  logic                                q_full_i,
  output logic                                push_o,
  output pqlda_pkg::cmd_t                     cmd_o
);

  localparam int unsigned CW = pqlda_pkg::COUNT_W;
  localparam int unsigned SW = pqlda_pkg::STRIDE_W;
  localparam int unsigned PW = CW + SW;
  localparam int unsigned CountMax = (1 << CW) - 1;
  localparam logic [CW-1:0] CountCap =
      CW'((MAX_SUBQUANTIZERS > CountMax) ? CountMax : MAX_SUBQUANTIZERS);
  localparam logic [SW-1:0] StrideCap = SW'(MAX_CODEBOOK);

  logic [CW-1:0] pos_q, pos_d;
  logic [CW-1:0] count;
  logic [SW-1:0] stride;
  logic [PW-1:0] prod0, prod1;
  logic [pqlda_pkg::BYTE_W-1:0] code0, code1;
  logic [CW:0]   pos_one, pos_end;
  logic          use1, last;

  // Effective count and stride, clamped to their legal ranges.
  always_comb begin
    if (cfg_i.num_sq == '0) begin
      count = CW'(1);
    end else if (cfg_i.num_sq > CountCap) begin
      count = CountCap;
    end else begin
      count = cfg_i.num_sq;
    end
    if (cfg_i.codebook == '0) begin
      stride = SW'(1);
    end else if (cfg_i.codebook > StrideCap) begin
      stride = StrideCap;
    end else begin
      stride = cfg_i.codebook;
    end
  end

  always_comb begin
    prod0 = PW'(pos_q) * PW'(stride);
    prod1 = prod0 + PW'(stride);
    if (cfg_i.packed_mode) begin
      code0 = {{(pqlda_pkg::BYTE_W - pqlda_pkg::NIBBLE_W){1'b0}},
               code_byte_i[pqlda_pkg::NIBBLE_W-1:0]};
    end else begin
      code0 = code_byte_i;
    end
    code1   = {{(pqlda_pkg::BYTE_W - pqlda_pkg::NIBBLE_W){1'b0}},
               code_byte_i[pqlda_pkg::BYTE_W-1:pqlda_pkg::NIBBLE_W]};
    pos_one = {1'b0, pos_q} + (CW + 1)'(1);
    // The high nibble counts only while the vector still has room for it.
    use1    = cfg_i.packed_mode && (pos_one < {1'b0, count});
    pos_end = use1 ? pos_one + (CW + 1)'(1) : pos_one;
    last    = pos_end >= {1'b0, count};
  end

  assign in_stall_o = q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    cmd_o.is_write = (operation_i == pqlda_pkg::OP_WRITE);
    cmd_o.addr0    = cmd_o.is_write ? entry_address_i
                                    : pqlda_pkg::ADDR_W'(prod0 + PW'(code0));
    cmd_o.addr1    = pqlda_pkg::ADDR_W'(prod1 + PW'(code1));
    cmd_o.value    = entry_value_i;
    cmd_o.use1     = use1;
    cmd_o.last     = last;
  end

  always_comb begin
    pos_d = pos_q;
    if (push_o && operation_i == pqlda_pkg::OP_CODE) begin
      pos_d = last ? '0 : pos_end[CW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else begin
      pos_q <= pos_d;
    end
  end

endmodule

// ----- rtl/pqlda_queue.sv -----
// Small first-in first-out queue of classified commands between front and back.
// Depends on pqlda_pkg.
`timescale 1ns / 1ps

module pqlda_queue (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  pqlda_pkg::cmd_t cmd_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            valid_o,
  output pqlda_pkg::cmd_t cmd_o
);

  localparam int unsigned Depth = pqlda_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = $clog2(Depth);
  localparam int unsigned CntW  = $clog2(Depth + 1);

  pqlda_pkg::cmd_t  slot_q [Depth];
  logic [PtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]  cnt_q, cnt_d;

  assign full_o  = (cnt_q == CntW'(Depth));
  assign valid_o = (cnt_q != '0);
  assign cmd_o   = slot_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == PtrW'(Depth - 1)) ? '0 : wr_ptr_q + PtrW'(1);
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == PtrW'(Depth - 1)) ? '0 : rd_ptr_q + PtrW'(1);
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + CntW'(1);
    end else if (pop_i && !push_i) begin
      cnt_d = cnt_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wr_ptr_q] <= cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

endmodule

// ----- rtl/pqlda_back.sv -----
// Back end: executes table writes, reads one or two entries per code byte and accumulates.
// Depends on pqlda_pkg and pqlda_ram.
`timescale 1ns / 1ps

module pqlda_back (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 q_valid_i,
  input  pqlda_pkg::cmd_t                      cmd_i,
  output logic                                 pop_o,
  output logic                                 out_valid_o,
  input  logic                                 out_stall_i,
  output logic signed [pqlda_pkg::SUM_W-1:0]   distance_o
);

  localparam int unsigned EW = pqlda_pkg::ENTRY_W;
  localparam int unsigned SW = pqlda_pkg::SUM_W;

  logic          adv;
  logic          rd_valid_q, rd_valid_d;
  logic          rd_use1_q, rd_use1_d;
  logic          rd_last_q, rd_last_d;
  logic          do_write, do_read;
  logic [EW-1:0] data0, data1;
  logic [SW-1:0] term0, term1;
  logic [SW-1:0] sum_q, sum_d, sum_new;
  logic [SW-1:0] dist_q, dist_d;
  logic          out_valid_q, out_valid_d;

  // The whole back end freezes only while a finished result is held and stalled.
  assign adv      = !(out_valid_q && out_stall_i);
  assign pop_o    = q_valid_i && adv;
  assign do_write = pop_o && cmd_i.is_write;
  assign do_read  = pop_o && !cmd_i.is_write;

  // Two copies of the table so that a packed byte reads both of its entries at once.
  pqlda_ram #(
    .WIDTH (EW),
    .DEPTH (pqlda_pkg::TABLE_DEPTH)
  ) u_ram_lo (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (cmd_i.addr0),
    .wdata_i (cmd_i.value),
    .re_i    (do_read),
    .raddr_i (cmd_i.addr0),
    .rdata_o (data0)
  );

  pqlda_ram #(
    .WIDTH (EW),
    .DEPTH (pqlda_pkg::TABLE_DEPTH)
  ) u_ram_hi (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .waddr_i (cmd_i.addr0),
    .wdata_i (cmd_i.value),
    .re_i    (do_read),
    .raddr_i (cmd_i.addr1),
    .rdata_o (data1)
  );

  always_comb begin
    rd_valid_d = rd_valid_q;
    rd_use1_d  = rd_use1_q;
    rd_last_d  = rd_last_q;
    if (adv) begin
      rd_valid_d = do_read;
      rd_use1_d  = cmd_i.use1;
      rd_last_d  = cmd_i.last;
    end
  end

  always_comb begin
    term0   = {{(SW - EW){data0[EW-1]}}, data0};
    term1   = rd_use1_q ? {{(SW - EW){data1[EW-1]}}, data1} : '0;
    sum_new = sum_q + term0 + term1;

    sum_d       = sum_q;
    dist_d      = dist_q;
    out_valid_d = out_valid_q && out_stall_i;
    if (rd_valid_q && adv) begin
      if (rd_last_q) begin
        sum_d       = '0;
        dist_d      = sum_new;
        out_valid_d = 1'b1;
      end else begin
        sum_d = sum_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_valid_q  <= 1'b0;
      rd_use1_q   <= 1'b0;
      rd_last_q   <= 1'b0;
      sum_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      rd_valid_q  <= rd_valid_d;
      rd_use1_q   <= rd_use1_d;
      rd_last_q   <= rd_last_d;
      sum_q       <= sum_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    dist_q <= dist_d;
  end

  assign out_valid_o = out_valid_q;
  assign distance_o  = dist_q;

endmodule

// ----- dv/tb_top.sv -----
// Self-checking testbench for the product-quantization lookup distance accumulator.
// Depends on pqlda_pkg and pq_lookup_distance_accumulator_core from the rtl folder.
`timescale 1ns / 1ps

module tb_top;

  // Sizes, codes and reset values taken from the package.
  localparam int unsigned ADDR_W                = pqlda_pkg::ADDR_W;
  localparam int unsigned ENTRY_W               = pqlda_pkg::ENTRY_W;
  localparam int unsigned SUM_W                 = pqlda_pkg::SUM_W;
  localparam int unsigned BYTE_W                = pqlda_pkg::BYTE_W;
  localparam int unsigned COUNT_W               = pqlda_pkg::COUNT_W;
  localparam int unsigned STRIDE_W              = pqlda_pkg::STRIDE_W;
  localparam int unsigned CFG_IDX_W             = pqlda_pkg::CFG_IDX_W;
  localparam int unsigned CFG_DATA_W            = pqlda_pkg::CFG_DATA_W;
  localparam int unsigned TABLE_DEPTH           = pqlda_pkg::TABLE_DEPTH;
  localparam int unsigned MAX_SUBQUANTIZERS_DEF = pqlda_pkg::MAX_SUBQUANTIZERS_DEF;
  localparam int unsigned MAX_CODEBOOK_DEF      = pqlda_pkg::MAX_CODEBOOK_DEF;
  localparam logic        OP_WRITE              = pqlda_pkg::OP_WRITE;
  localparam logic        OP_CODE               = pqlda_pkg::OP_CODE;
  localparam logic [CFG_IDX_W-1:0] CFG_NUM_SQ   = pqlda_pkg::CFG_NUM_SQ;
  localparam logic [CFG_IDX_W-1:0] CFG_CODEBOOK = pqlda_pkg::CFG_CODEBOOK;
  localparam logic [CFG_IDX_W-1:0] CFG_PACKED   = pqlda_pkg::CFG_PACKED;
  localparam logic [COUNT_W-1:0]   NUM_SQ_RST   = pqlda_pkg::NUM_SQ_RST;
  localparam logic [STRIDE_W-1:0]  CODEBOOK_RST = pqlda_pkg::CODEBOOK_RST;
  localparam logic                 PACKED_RST   = pqlda_pkg::PACKED_RST;

  // Cycles without any accepted request, result or register write before the run is
  // declared hung. A correct run never comes close: the longest quiet spell is the
  // settle pause before a register write.
  localparam int unsigned QUIET_LIMIT   = 2000;
  // Up to QUEUE_DEPTH requests may sit in the command queue, and a result passes the table
  // read and result registers after that, so this many idle cycles leave the block empty.
  localparam int unsigned SETTLE_CYCLES = 12;

  // One input request as the sender sees it.
  typedef struct {
    logic                      op;
    logic [ADDR_W-1:0]         addr;
    logic signed [ENTRY_W-1:0] value;
    logic [BYTE_W-1:0]         code;
  } pq_req_t;

  logic                      clk_i           = 1'b0;
  logic                      rst_ni          = 1'b0;
  logic                      cfg_we_i        = 1'b0;
  logic [CFG_IDX_W-1:0]      cfg_index_i     = CFG_NUM_SQ;
  logic [CFG_DATA_W-1:0]     cfg_data_i      = '0;
  logic                      in_valid_i      = 1'b0;
  logic                      operation_i     = OP_WRITE;
  logic [ADDR_W-1:0]         entry_address_i = '0;
  logic signed [ENTRY_W-1:0] entry_value_i   = '0;
  logic [BYTE_W-1:0]         code_byte_i     = '0;
  logic                      out_stall_i     = 1'b0;
  logic                      in_stall_o;
  logic                      out_valid_o;
  logic signed [SUM_W-1:0]   distance_o;

  pq_lookup_distance_accumulator_core i_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_index_i     (cfg_index_i),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .operation_i     (operation_i),
    .entry_address_i (entry_address_i),
    .entry_value_i   (entry_value_i),
    .code_byte_i     (code_byte_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .distance_o      (distance_o)
  );

  // Mirror of the block's state. Table entries that were never written stay X here, so
  // a lookup of one would show up as a mismatch; the stimulus is built to avoid them.
  logic signed [ENTRY_W-1:0] entry_store [TABLE_DEPTH];
  bit                        entry_known [TABLE_DEPTH];
  logic [SUM_W-1:0]          run_sum    = '0;
  int unsigned               sq_pos     = 0;
  logic [COUNT_W-1:0]        cfg_num_sq = NUM_SQ_RST;
  logic [STRIDE_W-1:0]       cfg_stride = CODEBOOK_RST;
  logic                      cfg_packed = PACKED_RST;

  // Distances predicted at request acceptance, oldest first.
  logic signed [SUM_W-1:0]   pending_distances [$];

  int unsigned               err_count    = 0;
  int unsigned               quiet_cycles = 0;
  // While set, neither the sender nor the receiver inserts idle cycles.
  bit                        steady_flow  = 1'b0;

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------------

  // The count and stride registers are clamped to their legal ranges before use.
  function automatic int unsigned active_count();
    if (cfg_num_sq == 0) return 1;
    if (cfg_num_sq > MAX_SUBQUANTIZERS_DEF) return MAX_SUBQUANTIZERS_DEF;
    return cfg_num_sq;
  endfunction

  function automatic int unsigned active_stride();
    if (cfg_stride == 0) return 1;
    if (cfg_stride > MAX_CODEBOOK_DEF) return MAX_CODEBOOK_DEF;
    return cfg_stride;
  endfunction

  // Table slot of a code at a given sub-quantizer position. Codes past the codebook
  // size run into the next table, and the address wraps to the table depth.
  function automatic logic [ADDR_W-1:0] slot_address(int unsigned pos, int unsigned code);
    return ADDR_W'(pos * active_stride() + code);
  endfunction

  function automatic void add_entry(int unsigned code);
    logic signed [ENTRY_W-1:0] v;
    v = entry_store[slot_address(sq_pos, code)];
    run_sum = run_sum + {{(SUM_W-ENTRY_W){v[ENTRY_W-1]}}, v};
    sq_pos++;
  endfunction

  // Applies one accepted request to the mirror and queues the distance it completes.
  function automatic void model_request(pq_req_t r);
    int unsigned m;
    m = active_count();
    if (r.op == OP_WRITE) begin
      entry_store[r.addr] = r.value;
      entry_known[r.addr] = 1'b1;
    end else begin
      // In packed mode the high nibble only counts while the vector still needs it;
      // a position already at or past a lowered count still takes the first code.
      if (cfg_packed) begin
        add_entry(r.code[3:0]);
        if (sq_pos < m) add_entry(r.code[7:4]);
      end else begin
        add_entry(r.code);
      end
      if (sq_pos >= m) begin
        pending_distances.push_back(run_sum);
        run_sum = '0;
        sq_pos  = 0;
      end
    end
  endfunction

  // ---------------------------------------------------------------------------------
  // Stimulus helpers. Every task starts and ends at a falling edge, where inputs change.
  // ---------------------------------------------------------------------------------

  // Offers one request, with random idle cycles ahead of it, and holds it until the
  // block takes it. The mirror is updated at the accepting edge.
  task automatic issue_request(input pq_req_t r);
    while (!steady_flow && $urandom_range(99, 0) < 14) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    operation_i     <= r.op;
    entry_address_i <= r.addr;
    entry_value_i   <= r.value;
    code_byte_i     <= r.code;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    model_request(r);
    @(negedge clk_i);
  endtask

  task automatic write_entry(input logic [ADDR_W-1:0] addr,
                             input logic signed [ENTRY_W-1:0] value);
    pq_req_t r;
    r.op    = OP_WRITE;
    r.addr  = addr;
    r.value = value;
    r.code  = BYTE_W'($urandom);
    issue_request(r);
  endtask

  // Mostly full-range random values, with the two extremes now and then.
  function automatic logic signed [ENTRY_W-1:0] draw_entry_value();
    if ($urandom_range(7, 0) != 0) return ENTRY_W'($urandom);
    return $urandom_range(1, 0) ? 32'sh7FFF_FFFF : 32'sh8000_0000;
  endfunction

  // Sends a code byte. Any table slot that this byte will read and that has not been
  // loaded yet is written first, so no lookup ever touches an unset entry.
  task automatic issue_code_byte(input logic [BYTE_W-1:0] code_val);
    pq_req_t           r;
    logic [ADDR_W-1:0] need [$];
    if (cfg_packed) begin
      need.push_back(slot_address(sq_pos, code_val[3:0]));
      if (sq_pos + 1 < active_count()) need.push_back(slot_address(sq_pos + 1, code_val[7:4]));
    end else begin
      need.push_back(slot_address(sq_pos, code_val));
    end
    foreach (need[i]) begin
      if (!entry_known[need[i]]) write_entry(need[i], draw_entry_value());
    end
    r.op    = OP_CODE;
    r.addr  = ADDR_W'($urandom);
    r.value = ENTRY_W'($urandom);
    r.code  = code_val;
    issue_request(r);
  endtask

  // Picks a code for a position: usually one whose slot is already loaded, so the
  // table is reused, otherwise any code of the current width.
  function automatic logic [BYTE_W-1:0] pick_code(int unsigned pos);
    int unsigned top;
    int unsigned start;
    int unsigned c;
    top   = cfg_packed ? 15 : 255;
    start = $urandom_range(top, 0);
    if ($urandom_range(99, 0) < 70) begin
      for (int i = 0; i <= top; i++) begin
        c = (start + i) % (top + 1);
        if (entry_known[slot_address(pos, c)]) return BYTE_W'(c);
      end
    end
    return BYTE_W'(start);
  endfunction

  task automatic issue_random_code();
    logic [BYTE_W-1:0] lo;
    logic [BYTE_W-1:0] hi;
    lo = pick_code(sq_pos);
    if (!cfg_packed) begin
      issue_code_byte(lo);
    end else begin
      // A high nibble that the vector no longer needs is pure noise.
      hi = (sq_pos + 1 < active_count()) ? pick_code(sq_pos + 1)
                                         : BYTE_W'($urandom_range(15, 0));
      issue_code_byte({hi[3:0], lo[3:0]});
    end
  endtask

  // Holds off the sender until every predicted distance has come back, then lets the
  // queue run empty of requests that complete no vector.
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_distances.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  // Register writes happen only with the block drained; callers see to that.
  task automatic write_config(input logic [CFG_IDX_W-1:0] idx,
                              input logic [CFG_DATA_W-1:0] value);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= value;
    @(posedge clk_i);
    case (idx)
      CFG_NUM_SQ:   cfg_num_sq = value[COUNT_W-1:0];
      CFG_CODEBOOK: cfg_stride = value[STRIDE_W-1:0];
      CFG_PACKED:   cfg_packed = value[0];
      default: ;
    endcase
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    @(negedge clk_i);
  endtask

  task automatic set_config(input int unsigned m, input int unsigned k, input int unsigned p);
    drain_results();
    write_config(CFG_NUM_SQ, CFG_DATA_W'(m));
    write_config(CFG_CODEBOOK, CFG_DATA_W'(k));
    write_config(CFG_PACKED, CFG_DATA_W'(p));
  endtask

  // ---------------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------------

  // Reset settings: eight packed codes per vector, stride sixteen. Slot 0 of the first two
  // tables holds the largest and smallest entry, and the top table address is written too.
  task automatic test_reset_defaults();
    write_entry('0, 32'sh7FFF_FFFF);
    write_entry(ADDR_W'(16), 32'sh8000_0000);
    write_entry('1, draw_entry_value());
    issue_code_byte(8'h00);
    issue_code_byte(8'hFF);
    issue_code_byte(8'h5A);
    issue_code_byte(8'hF0);
  endtask

  // Zero count and zero stride clamp to one, so every byte is a vector of its own and
  // a large code reads far past its one-entry table.
  task automatic test_clamped_counts();
    set_config(0, 0, 0);
    issue_code_byte(8'h00);
    issue_code_byte(8'hFF);
  endtask

  // Odd count in packed mode: the high nibble of the last byte is dropped. Then a
  // vector is begun packed and finished in byte mode.
  task automatic test_odd_count_and_mode_switch();
    set_config(3, 16, 1);
    issue_code_byte(8'h21);
    issue_code_byte(8'hF3);
    issue_code_byte(8'h54);
    drain_results();
    write_config(CFG_PACKED, CFG_DATA_W'(0));
    issue_code_byte(8'h07);
  endtask

  // A vector is begun, then the count drops below the position reached: the next byte
  // still adds its code and closes the vector.
  task automatic test_count_lowered();
    issue_code_byte(8'h10);
    drain_results();
    write_config(CFG_NUM_SQ, CFG_DATA_W'(1));
    issue_code_byte(8'h22);
  endtask

  // Streams of random vectors under a run of settings: the reset values, the largest
  // and clamped-high sizes, the smallest, the zero ones, then random mostly small ones. Since settings change
  // between phases whatever the position, vectors also straddle setting changes.
  task automatic test_random_streams();
    int unsigned       n_items;
    int unsigned       m;
    int unsigned       k;
    int unsigned       p;
    logic [ADDR_W-1:0] a;
    for (int phase = 0; phase < 11; phase++) begin
      n_items = 115;
      case (phase)
        0: begin
          m = 8; k = 16; p = 1; n_items = 120;
        end
        1: begin
          m = 64; k = 256; p = 0; n_items = 90;
        end
        2: begin
          m = 127; k = 511; p = 1; n_items = 80;
        end
        3: begin
          m = 1; k = 1; p = 0; n_items = 60;
        end
        4: begin
          m = 0; k = 0; p = 1; n_items = 60;
        end
        default: begin
          m = ($urandom_range(3, 0) == 0) ? $urandom_range(64, 13) : $urandom_range(12, 1);
          k = ($urandom_range(4, 0) == 0) ? 256 : $urandom_range(48, 1);
          p = $urandom_range(1, 0);
        end
      endcase
      set_config(m, k, p);
      // One phase runs with no idle cycles on either side.
      steady_flow = (phase == 6);
      for (int i = 0; i < n_items; i++) begin
        // Once mid-stream the sender waits for every outstanding distance.
        if (phase == 8 && i == 40) drain_results();
        if ($urandom_range(99, 0) < 15) begin
          // Table rewrites, half anywhere in the store and half inside live tables.
          if ($urandom_range(1, 0)) begin
            a = ADDR_W'($urandom);
          end else begin
            a = slot_address($urandom_range(active_count() - 1, 0),
                             $urandom_range(cfg_packed ? 15 : 255, 0));
          end
          write_entry(a, draw_entry_value());
        end else begin
          issue_random_code();
        end
      end
    end
    steady_flow = 1'b0;
  endtask

  // ---------------------------------------------------------------------------------
  // Receiver, checker and watchdog
  // ---------------------------------------------------------------------------------

  always @(negedge clk_i) begin
    out_stall_i <= !steady_flow && ($urandom_range(99, 0) < 14);
  end

  // Each distance taken from the block must match the oldest prediction.
  always @(posedge clk_i) begin
    logic signed [SUM_W-1:0] want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_distances.size() == 0) begin
        $display("%0t: distance with none expected: expected none actual %0d",
                 $time, distance_o);
        err_count++;
      end else begin
        want = pending_distances.pop_front();
        if (distance_o !== want) begin
          $display("%0t: distance mismatch: expected %0d actual %0d", $time, want, distance_o);
          err_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || cfg_we_i || (in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------------
  // Test sequence
  // ---------------------------------------------------------------------------------

  initial begin
    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_reset_defaults();
    test_clamped_counts();
    test_odd_count_and_mode_switch();
    test_count_lowered();
    test_random_streams();
    // Anything still queued in the block must come out and match.
    drain_results();
    if (err_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

// ----- pq_lookup_distance_accumulator_core.f -----
rtl/pqlda_pkg.sv
rtl/pqlda_ram.sv
rtl/pqlda_front.sv
rtl/pqlda_queue.sv
rtl/pqlda_back.sv
rtl/pq_lookup_distance_accumulator_core.sv
dv/tb_top.sv
